// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the interval subscription matcher.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, off while reset is asserted.
`define ISM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge, also during reset.
`define ISM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ism_pkg.sv =====
// Package of the interval subscription matcher: sizes, command codes, memory word type.
// Depends on nothing.
package ism_pkg;
	localparam int SUBS       = 1024;
	localparam int ATTRS      = 16;
	localparam int VALUE_BITS = 20;
	localparam int SUB_BITS   = 10;
	localparam int ATTR_BITS  = 4;
	localparam int COUNT_BITS = 11;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_PAIR = 1'b1;

	// one word per subscription: per-event fail mark and constrained attributes
	typedef struct packed {
		logic             failed;
		logic [ATTRS-1:0] cmap;
	} sub_word_t;
endpackage

// ===== sv/interval_subscription_matcher.sv =====
// Interval subscription matcher: constraint store, per-pair sweep, match count.
// Depends on ism_pkg and assert_macros.svh.
//
//  channel | payload                                   | dir | handshake
//  --------+-------------------------------------------+-----+-------------------
//  input   | command subscription_id attribute bounds.. | in  | in_valid/in_stall
//  output  | match_count                               | out | out_valid/out_stall
//
// The input payload runs command, subscription_id, attribute, low_bound,
// high_bound, event_value, last_pair.
// An add reads the subscription word, then writes it back.
// In a publication pair the sweep reads and writes one
// subscription word per cycle through the single port pair of the word memory,
// then the drain state and the result state follow.
// After reset a clearing pass over all SUBS words zeroes the word memory; no item
// is accepted meanwhile. The bound memory is never cleared.
// A result waiting under out_stall does not block adds or pairs; only a second
// result holds the block until the first one is taken.
`include "assert_macros.svh"

module interval_subscription_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [ism_pkg::SUB_BITS-1:0]    subscription_id,
	input  logic [ism_pkg::ATTR_BITS-1:0]   attribute,
	input  logic [ism_pkg::VALUE_BITS-1:0]  low_bound,
	input  logic [ism_pkg::VALUE_BITS-1:0]  high_bound,
	input  logic [ism_pkg::VALUE_BITS-1:0]  event_value,
	input  logic                            last_pair,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ism_pkg::COUNT_BITS-1:0]  match_count
);
	import ism_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_WR,
		ST_SWEEP,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	localparam int BIDX_BITS = SUB_BITS + ATTR_BITS;

	// bounds, indexed {attribute, subscription}; {high, low}
	logic [2*VALUE_BITS-1:0] bound_mem [SUBS*ATTRS];
	// per-subscription word: fail mark and constrained-attribute map
	sub_word_t               sub_mem   [SUBS];

	state_t                  state_q;
	logic [SUB_BITS-1:0]     idx_q;
	logic [SUB_BITS-1:0]     sid_q;
	logic [ATTR_BITS-1:0]    att_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic                    last_q;
	logic [ATTRS-1:0]        seen_q;
	logic [COUNT_BITS-1:0]   fail_cnt_q;
	logic                    out_valid_q;
	logic [COUNT_BITS-1:0]   match_count_q;

	logic                    rd_vld_s1;
	logic [SUB_BITS-1:0]     addr_s1;
	logic [2*VALUE_BITS-1:0] bound_rd_s1;
	sub_word_t               sub_rd_s1;

	logic                    accept;
	logic                    add_acc;
	logic                    pair_acc;
	logic                    sweep_rd;
	logic                    sub_re;
	logic [SUB_BITS-1:0]     sub_raddr;
	logic                    sub_we;
	logic [SUB_BITS-1:0]     sub_waddr;
	sub_word_t               sub_wdata;
	logic [VALUE_BITS-1:0]   lo_s1;
	logic [VALUE_BITS-1:0]   hi_s1;
	logic                    fail_now;
	logic                    can_emit;
	logic                    emit;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && (state_q == ST_IDLE);
	assign add_acc     = accept && (command == CMD_ADD);
	assign pair_acc    = accept && (command == CMD_PAIR);
	assign sweep_rd    = (state_q == ST_SWEEP);
	assign sub_re      = add_acc || sweep_rd;
	assign sub_raddr   = add_acc ? subscription_id : idx_q;
	assign out_valid   = out_valid_q;
	assign match_count = match_count_q;
	assign can_emit    = !out_valid_q || !out_stall;
	// launch the count of a finished publication
	assign emit        = (state_q == ST_RESULT) && last_q && can_emit;

	// Check one subscription: an earlier fail mark, a range miss on the pair's attribute,
	// or on the last pair a constrained attribute the publication never gave.
	always_comb begin
		lo_s1    = bound_rd_s1[VALUE_BITS-1:0];
		hi_s1    = bound_rd_s1[2*VALUE_BITS-1:VALUE_BITS];
		fail_now = sub_rd_s1.failed
			|| (sub_rd_s1.cmap[att_q] && ((val_q < lo_s1) || (val_q > hi_s1)))
			|| (last_q && (|(sub_rd_s1.cmap & ~seen_q)));
	end

	// Word memory write port: clearing pass, add write-back, sweep write-back.
	always_comb begin
		sub_we    = 1'b0;
		sub_waddr = idx_q;
		sub_wdata = '0;
		if (state_q == ST_CLEAR) begin
			sub_we = 1'b1;
		end else if (state_q == ST_ADD_WR) begin
			sub_we         = 1'b1;
			sub_waddr      = sid_q;
			sub_wdata      = sub_rd_s1;
			sub_wdata.cmap = sub_rd_s1.cmap | (ATTRS'(1) << att_q);
		end else if (rd_vld_s1) begin
			sub_we           = 1'b1;
			sub_waddr        = addr_s1;
			sub_wdata.cmap   = sub_rd_s1.cmap;
			// drop the fail marks once the publication is counted
			sub_wdata.failed = fail_now && !last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (add_acc) begin
			bound_mem[{attribute, subscription_id}] <= {high_bound, low_bound};
		end
		if (sweep_rd) begin
			bound_rd_s1 <= bound_mem[BIDX_BITS'({att_q, idx_q})];
		end
	end

	always_ff @(posedge clk) begin
		if (sub_we) begin
			sub_mem[sub_waddr] <= sub_wdata;
		end
		if (sub_re) begin
			sub_rd_s1 <= sub_mem[sub_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			idx_q         <= '0;
			sid_q         <= '0;
			att_q         <= '0;
			val_q         <= '0;
			last_q        <= 1'b0;
			seen_q        <= '0;
			fail_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
			match_count_q <= '0;
			rd_vld_s1     <= 1'b0;
			addr_s1       <= '0;
		end else begin
			rd_vld_s1 <= sweep_rd;
			addr_s1   <= idx_q;
			if (rd_vld_s1 && last_q && fail_now) begin
				fail_cnt_q <= fail_cnt_q + COUNT_BITS'(1);
			end
			// hold a stalled result, replace a taken one
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + SUB_BITS'(1);
					if (idx_q == SUB_BITS'(SUBS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (add_acc) begin
						sid_q   <= subscription_id;
						att_q   <= attribute;
						state_q <= ST_ADD_WR;
					end else if (pair_acc) begin
						att_q      <= attribute;
						val_q      <= event_value;
						last_q     <= last_pair;
						seen_q     <= seen_q | (ATTRS'(1) << attribute);
						idx_q      <= '0;
						fail_cnt_q <= '0;
						state_q    <= ST_SWEEP;
					end
				end
				ST_ADD_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					idx_q <= idx_q + SUB_BITS'(1);
					if (idx_q == SUB_BITS'(SUBS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						match_count_q <= COUNT_BITS'(SUBS) - fail_cnt_q;
						seen_q        <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ISM_ASSERT(a_accept_idle, (in_valid && !in_stall) |-> (state_q == ST_IDLE), "busy accept")
	`ISM_ASSERT(a_s1_in_sweep, rd_vld_s1 |-> (state_q == ST_SWEEP || state_q == ST_DRAIN), "stray")
	`ISM_ASSERT(a_cnt_range, fail_cnt_q <= COUNT_BITS'(SUBS), "fail count beyond slot count")
	`ISM_ASSERT(a_no_out_clear, (state_q == ST_CLEAR) |-> !out_valid_q, "result during clearing pass")
endmodule

// ===== verif/interval_subscription_matcher_tb.sv =====
// Testbench of the interval subscription matcher: directed and random constraint
// adds and publications, checked against an in-bench match counter.
// Depends on ism_pkg and the interval_subscription_matcher RTL.
`timescale 1ns / 100ps

// Holds the constraint table and the pending match counts.
class match_scoreboard;
	logic [ism_pkg::VALUE_BITS-1:0] lower_bound_q[ism_pkg::SUBS*ism_pkg::ATTRS];
	logic [ism_pkg::VALUE_BITS-1:0] upper_bound_q[ism_pkg::SUBS*ism_pkg::ATTRS];
	bit constrained_q[ism_pkg::SUBS*ism_pkg::ATTRS];
	bit failed_q[ism_pkg::SUBS];
	bit [ism_pkg::ATTRS-1:0] seen_attrs;
	logic [ism_pkg::COUNT_BITS-1:0] pending_counts[$];
	int mismatches;

	function new();
		foreach (constrained_q[i]) constrained_q[i] = 0;
		foreach (failed_q[i]) failed_q[i] = 0;
		seen_attrs = '0;
		mismatches = 0;
	endfunction

	// Update the table for one accepted item; queue a count on the last pair.
	function void note_item(logic cmd, logic [9:0] sid, logic [3:0] att,
			logic [19:0] lo, logic [19:0] hi, logic [19:0] val, logic last);
		int idx;
		int nfail;
		int left_cnt;
		if (cmd == ism_pkg::CMD_ADD) begin
			idx = sid * ism_pkg::ATTRS + att;
			lower_bound_q[idx] = lo;
			upper_bound_q[idx] = hi;
			constrained_q[idx] = 1;
			return;
		end
		seen_attrs[att] = 1;
		for (int s = 0; s < ism_pkg::SUBS; s++) begin
			idx = s * ism_pkg::ATTRS + att;
			if (constrained_q[idx] && (val < lower_bound_q[idx] || val > upper_bound_q[idx]))
				failed_q[s] = 1;
		end
		if (!last)
			return;
		nfail = 0;
		for (int s = 0; s < ism_pkg::SUBS; s++) begin
			for (int a = 0; a < ism_pkg::ATTRS; a++)
				if (!seen_attrs[a] && constrained_q[s * ism_pkg::ATTRS + a])
					failed_q[s] = 1;
			if (failed_q[s])
				nfail++;
			failed_q[s] = 0;
		end
		left_cnt = ism_pkg::SUBS - nfail;
		pending_counts.insert(pending_counts.size(), left_cnt[ism_pkg::COUNT_BITS-1:0]);
		seen_attrs = '0;
	endfunction

	function void check_count(logic [ism_pkg::COUNT_BITS-1:0] got);
		logic [ism_pkg::COUNT_BITS-1:0] want;
		if (pending_counts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected match_count %0d", got);
			return;
		end
		want = pending_counts.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("match_count mismatch: expected %0d, got %0d", want, got);
		end
	endfunction
endclass

module interval_subscription_matcher_tb;
	import ism_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic command = CMD_ADD;
	logic [SUB_BITS-1:0] subscription_id = '0;
	logic [ATTR_BITS-1:0] attribute = '0;
	logic [VALUE_BITS-1:0] low_bound = '0;
	logic [VALUE_BITS-1:0] high_bound = '0;
	logic [VALUE_BITS-1:0] event_value = '0;
	logic last_pair = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [COUNT_BITS-1:0] match_count;

	// idle percentages of sender and receiver, changed per phase
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit stim_done = 0;

	match_scoreboard counts = new();

	interval_subscription_matcher dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stall the receiver at random; check every accepted count.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			counts.check_count(match_count);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Idle at random, present one item and hold it until accepted. Valid stays
	// high afterwards; the next send_item replaces the item or drops valid.
	task automatic send_item(logic cmd, logic [SUB_BITS-1:0] sid, logic [ATTR_BITS-1:0] att,
			logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
			logic [VALUE_BITS-1:0] val, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		subscription_id <= sid;
		attribute <= att;
		low_bound <= lo;
		high_bound <= hi;
		event_value <= val;
		last_pair <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		counts.note_item(cmd, sid, att, lo, hi, val, last);
	endtask

	// Drop valid after the last item of a stretch.
	task automatic drop_valid();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic add_rule(logic [SUB_BITS-1:0] sid, logic [ATTR_BITS-1:0] att,
			logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi);
		send_item(CMD_ADD, sid, att, lo, hi, VALUE_BITS'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic publish_pair(logic [ATTR_BITS-1:0] att, logic [VALUE_BITS-1:0] val,
			logic last);
		send_item(CMD_PAIR, SUB_BITS'($urandom), att, VALUE_BITS'($urandom),
			VALUE_BITS'($urandom), val, last);
	endtask

	// One well-formed random publication, biased toward values near the bounds.
	task automatic random_publication();
		int npairs;
		npairs = $urandom_range(1, 5);
		for (int p = 0; p < npairs; p++)
			publish_pair(ATTR_BITS'($urandom_range(3)),
				$urandom_range(1) ? VALUE_BITS'($urandom_range(1000)) : VALUE_BITS'($urandom),
				p == npairs - 1);
	endtask

	task automatic random_phase(int n);
		int left;
		left = n;
		while (left > 0) begin
			if ($urandom_range(99) < 40) begin
				// rules mostly on a few ids and attributes so publications bite
				add_rule($urandom_range(1) ? SUB_BITS'($urandom_range(15)) : SUB_BITS'($urandom),
					$urandom_range(4) ? ATTR_BITS'($urandom_range(3)) : ATTR_BITS'($urandom),
					VALUE_BITS'($urandom_range(600)),
					$urandom_range(3) ? VALUE_BITS'($urandom_range(300, 1000))
						: VALUE_BITS'($urandom));
				left--;
			end else begin
				random_publication();
				left -= 3;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, bound extremes, empty interval, overwrite,
		// missing attribute, repeated pair, pair on an unused attribute
		publish_pair(4'd0, 20'd0, 1'b1);
		add_rule(10'd0, 4'd0, 20'd0, 20'hFFFFF);
		add_rule(SUB_BITS'(SUBS - 1), ATTR_BITS'(ATTRS - 1), 20'hFFFFF, 20'hFFFFF);
		add_rule(10'd5, 4'd2, 20'd100, 20'd50);
		publish_pair(4'd0, 20'hFFFFF, 1'b0);
		publish_pair(ATTR_BITS'(ATTRS - 1), 20'hFFFFF, 1'b0);
		publish_pair(4'd2, 20'd75, 1'b1);
		add_rule(10'd5, 4'd2, 20'd10, 20'd90);
		publish_pair(4'd2, 20'd75, 1'b0);
		publish_pair(4'd2, 20'd95, 1'b0);
		publish_pair(4'd7, 20'd1, 1'b1);
		publish_pair(ATTR_BITS'(ATTRS - 1), 20'hFFFFE, 1'b0);
		add_rule(10'd9, 4'd7, 20'd1, 20'd1);
		publish_pair(4'd7, 20'd1, 1'b0);
		publish_pair(4'd0, 20'd0, 1'b1);
		add_rule(10'h2AA, 4'hA, 20'hAAAAA, 20'hD5555);
		add_rule(10'h155, 4'h5, 20'h55555, 20'hAAAAA);
		publish_pair(4'hA, 20'hAAAAA, 1'b0);
		publish_pair(4'h5, 20'h55555, 1'b1);
		publish_pair(4'd3, 20'd0, 1'b1);

		random_phase(200);
		// hold off until every count is back
		drop_valid();
		wait (counts.pending_counts.size() == 0);
		send_idle_pct = 85;
		random_phase(200);
		send_idle_pct = 0;
		stall_pct = 85;
		random_phase(200);
		send_idle_pct = 7;
		stall_pct = 7;
		random_phase(300);
		drop_valid();
		stall_pct = 0;

		wait (counts.pending_counts.size() == 0);
		repeat (3 * SUBS) @(posedge clk);
		if (counts.mismatches == 0 && counts.pending_counts.size() == 0)
			$display("** interval_subscription_matcher: PASSED **");
		else
			$display("** interval_subscription_matcher: FAILED **");
		$finish;
	end

	// Bound the run: ~900 items, each pair a full sweep of the word memory, plus stalls.
	initial begin
		#20000000;
		$display("** interval_subscription_matcher: FAILED **");
		$finish;
	end
endmodule

// ===== interval_subscription_matcher.f =====
+incdir+sv
sv/ism_pkg.sv
sv/interval_subscription_matcher.sv
verif/interval_subscription_matcher_tb.sv
